>>> design/smbs_pkg.sv
`default_nettype none

package smbs_pkg;

    // Flat probe index: rows and columns in use are at most 63 each.
    localparam int IDX_W = 12;
    // Width of the row and column counts, and of the divisor.
    localparam int CNT_W = 6;
    // Signed search bound, wide enough to hold -1.
    localparam int BND_W = IDX_W + 1;

    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_COLS_IN_USE = 1'b1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] quot;
        logic [CNT_W-1:0] rem;
    } div_resp_t;

endpackage

`default_nettype wire

>>> design/smbs_ram.sv
`default_nettype none

module smbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

>>> design/smbs_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module smbs_div import smbs_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [IDX_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output div_resp_t             resp
);

    localparam int STEP_W = $clog2(IDX_W + 1);

    logic [IDX_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[IDX_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = STEP_W'(IDX_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[IDX_W-2:0], ge};
            rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign resp.done = done_reg;
    assign resp.quot = quo_reg;
    assign resp.rem  = rem_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_start_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && cnt_reg == STEP_W'(IDX_W))
        else $error("divider did not start");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> rem_reg < dvs_reg && !busy_reg)
        else $error("remainder not below divisor");

endmodule

`default_nettype wire

>>> design/sorted_matrix_binary_search_top.sv
// Binary search over a matrix of signed words held sorted ascending in row-major
// order. A load request (s_tuser = 0) writes one entry into on-chip memory if its
// row and column lie within the matrix, and is then answered. A search request
// (s_tuser = 1) probes the flat index range 0 .. rows*cols-1; each probe splits its
// index into row and column with a 12-step restoring divider, then reads the memory
// (registered read) and compares. A search makes at most ceil(log2(rows*cols + 1))
// probes, so at most 11 for a 32 by 32 matrix. One request is handled at a time; a
// finished reply waits in the output register while the next request is taken. The
// memory needs no clearing: only written entries may be searched.
`default_nettype none

module sorted_matrix_binary_search_top import smbs_pkg::*; #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [5:0]  cfg_wdata,
    // requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // row[4:0], col[9:5], value[41:10], zero pad
    input  wire logic        s_tuser,   // func
    // replies
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // found[0], zero pad
    output logic             m_tuser    // is_search_reply
);

    localparam int WORD_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_MID   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        rows_reg, cols_reg;
    logic [WORD_W-1:0]       key_reg, key_next;
    logic signed [BND_W-1:0] lo_reg, lo_next;
    logic signed [BND_W-1:0] hi_reg, hi_next;
    logic [IDX_W-1:0]        mid_reg, mid_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic                    res_kind_reg, res_kind_next;
    logic                    res_found_reg, res_found_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_kind_reg, m_kind_next;
    logic                    m_found_reg, m_found_next;

    logic [4:0]              in_row, in_col;
    logic [CNT_W-1:0]        r_sat, c_sat;
    logic [IDX_W-1:0]        prod;
    logic signed [BND_W:0]   mid_sum;
    logic                    accept;
    logic                    ram_we;
    logic [31:0]             waddr_full, raddr_full;
    logic [WORD_W-1:0]       rdata;
    logic                    div_start;
    div_resp_t               div_resp;

    assign in_row = s_tdata[4:0];
    assign in_col = s_tdata[9:5];
    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Counts saturate at the matrix size.
    assign r_sat = ({5'd0, rows_reg} > 11'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_reg;
    assign c_sat = ({5'd0, cols_reg} > 11'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cols_reg;
    assign prod  = IDX_W'(r_sat * c_sat);

    assign mid_sum    = {lo_reg[BND_W-1], lo_reg} + {hi_reg[BND_W-1], hi_reg};
    assign div_start  = (state_reg == S_MID) && (lo_reg <= hi_reg);

    assign ram_we     = accept && (s_tuser == FUNC_LOAD)
                        && ({6'd0, in_row} < 11'(MAX_ROWS))
                        && ({6'd0, in_col} < 11'(MAX_COLS));
    assign waddr_full = 32'(in_row) * 32'(MAX_COLS) + 32'(in_col);
    assign raddr_full = 32'(div_resp.quot) * 32'(MAX_COLS) + 32'(div_resp.rem);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= '0;
            cols_reg <= CNT_W'(1);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_ROWS_IN_USE: rows_reg <= cfg_wdata;
                REG_COLS_IN_USE: cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    smbs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr_full[AW-1:0]),
        .wdata (s_tdata[10 +: WORD_W]),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    smbs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mid_sum[IDX_W:1]),
        .divisor  (c_sat),
        .resp     (div_resp)
    );

    always_comb begin
        state_next     = state_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        addr_next      = addr_reg;
        res_kind_next  = res_kind_reg;
        res_found_next = res_found_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_kind_next    = m_kind_reg;
        m_found_next   = m_found_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    key_next       = s_tdata[10 +: WORD_W];
                    res_kind_next  = s_tuser;
                    res_found_next = 1'b0;
                    state_next     = (s_tuser == FUNC_LOAD) ? S_DONE : S_SETUP;
                end
            end
            S_SETUP: begin
                if (r_sat == '0 || c_sat == '0) begin
                    state_next = S_DONE;
                end else begin
                    lo_next    = '0;
                    hi_next    = $signed({1'b0, prod}) - BND_W'(1);
                    state_next = S_MID;
                end
            end
            S_MID: begin
                if (lo_reg > hi_reg) begin
                    state_next = S_DONE;
                end else begin
                    mid_next   = mid_sum[IDX_W:1];
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_resp.done) begin
                    addr_next  = raddr_full[AW-1:0];
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (rdata == key_reg) begin
                    res_found_next = 1'b1;
                    state_next     = S_DONE;
                end else begin
                    if ($signed(rdata) > $signed(key_reg)) begin
                        hi_next = $signed({1'b0, mid_reg}) - BND_W'(1);
                    end else begin
                        lo_next = $signed({1'b0, mid_reg}) + BND_W'(1);
                    end
                    state_next = S_MID;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = res_kind_reg;
                    m_found_next = res_found_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            lo_reg      <= '0;
            hi_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
        end
        key_reg       <= key_next;
        mid_reg       <= mid_next;
        addr_reg      <= addr_next;
        res_kind_reg  <= res_kind_next;
        res_found_reg <= res_found_next;
        m_kind_reg    <= m_kind_next;
        m_found_reg   <= m_found_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {7'd0, m_found_reg};

    a_load_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_kind_reg |-> !m_found_reg)
        else $error("load acknowledge reports a hit");

    a_probe_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CMP |-> lo_reg <= hi_reg
            && $signed({1'b0, mid_reg}) >= lo_reg && $signed({1'b0, mid_reg}) <= hi_reg)
        else $error("probe outside search bounds");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready && !$stable(state_reg))
        else $error("request taken while busy");

endmodule

`default_nettype wire

>>> sim/smbs_checker.sv
`default_nettype none

module smbs_checker import smbs_pkg::*; #(
    parameter int MAT_ROWS = 32,
    parameter int MAT_COLS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [5:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [47:0] s_tdata,   // row[4:0], col[9:5], value[41:10], zero pad
    input  wire logic        s_tuser,   // func
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // found[0], zero pad
    input  wire logic        m_tuser,   // is_search_reply
    output int               mismatches,
    output int               outstanding,
    output int               hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic is_search;
        logic found;
    } reply_t;

    reply_t             replies_due[$];
    logic signed [31:0] cells[MAT_ROWS*MAT_COLS];
    logic [CNT_W-1:0]   rows_reg;
    logic [CNT_W-1:0]   cols_reg;

    // Binary search over the flat row-major range of the shape in use.
    function automatic logic key_present(input logic signed [31:0] key);
        int                 r;
        int                 c;
        int                 lo;
        int                 hi;
        int                 mid;
        logic signed [31:0] probe;
        r = (rows_reg > MAT_ROWS) ? MAT_ROWS : int'(rows_reg);
        c = (cols_reg > MAT_COLS) ? MAT_COLS : int'(cols_reg);
        lo = 0;
        hi = r * c - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            probe = cells[(mid / c) * MAT_COLS + mid % c];
            if (probe == key)
                return 1'b1;
            if (probe > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return 1'b0;
    endfunction

    always @(posedge aclk) begin
        reply_t want;
        reply_t got;
        if (!aresetn) begin
            rows_reg = '0;
            cols_reg = 6'd1;
            replies_due.delete();
            mismatches = 0;
            hits = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_ROWS_IN_USE)
                    rows_reg = cfg_wdata;
                else
                    cols_reg = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                want = '0;
                if (s_tuser == FUNC_LOAD) begin
                    cells[s_tdata[4:0] * MAT_COLS + s_tdata[9:5]] = s_tdata[41:10];
                end else begin
                    want.is_search = 1'b1;
                    want.found = key_present(s_tdata[41:10]);
                    hits += want.found;
                end
                replies_due.insert(replies_due.size(), want);
            end
            if (m_tvalid && m_tready) begin
                got.is_search = m_tuser;
                got.found = m_tdata[0];
                if (replies_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected reply: expected none, got is_search_reply=%0b found=%0b",
                             $time, got.is_search, got.found);
                end else begin
                    want = replies_due.pop_front();
                    if (got.is_search !== want.is_search) begin
                        mismatches++;
                        $display("%0t: is_search_reply: expected %0b, got %0b",
                                 $time, want.is_search, got.is_search);
                    end
                    if (got.found !== want.found) begin
                        mismatches++;
                        $display("%0t: found: expected %0b, got %0b",
                                 $time, want.found, got.found);
                    end
                end
            end
        end
        outstanding = replies_due.size();
    end

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench import smbs_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAT_ROWS    = 32;
    localparam int MAT_COLS    = 32;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 160;
    localparam int ITEM_TARGET = 1800;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_addr  = '0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic [47:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tuser;

    int mismatches;
    int outstanding;
    int hits;

    logic signed [31:0] shadow[MAT_ROWS*MAT_COLS];
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_go;
    int idle_cycles;
    int n_loads;
    int n_searches;
    int n_shapes;
    int box_r;
    int box_c;

    sorted_matrix_binary_search_top #(
        .MAX_ROWS   (MAT_ROWS),
        .MAX_COLS   (MAT_COLS),
        .DATA_WIDTH (32)
    ) dut (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );

    smbs_checker #(.MAT_ROWS(MAT_ROWS), .MAT_COLS(MAT_COLS)) u_checker (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .mismatches, .outstanding, .hits
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // reply side: random stalls, or one long hold-off on request
    always begin
        @(posedge aclk);
        if (hold_go) begin
            hold_go = 1'b0;
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge aclk);
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(input logic f, input logic [4:0] r, input logic [4:0] c,
                        input logic [31:0] v);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {6'b0, v, c, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (f == FUNC_LOAD) begin
            shadow[r * MAT_COLS + c] = v;
            n_loads++;
        end else begin
            n_searches++;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_shape(input logic [5:0] rows, input logic [5:0] cols);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_ROWS_IN_USE;
        cfg_wdata <= rows;
        @(posedge aclk);
        cfg_addr  <= REG_COLS_IN_USE;
        cfg_wdata <= cols;
        @(posedge aclk);
        cfg_we <= 1'b0;
        box_r = (rows > MAT_ROWS) ? MAT_ROWS : int'(rows);
        box_c = (cols > MAT_COLS) ? MAT_COLS : int'(cols);
        n_shapes++;
    endtask

    // Sorted row-major contents: spread over the whole word range, or
    // clustered with repeats.
    task automatic fill_box();
        int     n;
        bit     tight;
        longint span;
        longint acc;
        n = box_r * box_c;
        if (n == 0)
            return;
        tight = ($urandom_range(2) == 0);
        acc = longint'($urandom_range(2000)) - 1000;
        span = 64'sh1_0000_0000 / (n + 1);
        for (int k = 0; k < n; k++) begin
            if (tight)
                acc += $urandom_range(3);
            else
                acc = longint'(k) * span + longint'($urandom_range(32'(span - 1)))
                      - 64'sd2147483648;
            send(FUNC_LOAD, 5'(k / box_c), 5'(k % box_c), acc[31:0]);
        end
    endtask

    function automatic logic [31:0] pick_key();
        int          sel;
        int          k;
        logic [31:0] hit;
        sel = $urandom_range(99);
        if (box_r * box_c == 0 || sel >= 85)
            return $urandom;
        k = $urandom_range(box_r * box_c - 1);
        hit = shadow[(k / box_c) * MAT_COLS + k % box_c];
        if (sel < 50)
            return hit;
        if (sel < 70)
            return $urandom_range(1) ? hit + 32'd1 : hit - 32'd1;
        if (sel < 78)
            return shadow[0] - 32'd1;
        return shadow[(box_r - 1) * MAT_COLS + box_c - 1] + 32'd1;
    endfunction

    task automatic run_phase(input logic [5:0] rows, input logic [5:0] cols, input bit hold);
        int n;
        if (n_loads + n_searches < ITEM_TARGET / 3) begin
            send_idle_pct = 37;
            recv_idle_pct = 48;
        end else if (n_loads + n_searches < 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 48;
            recv_idle_pct = 37;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        set_shape(rows, cols);
        if (hold)
            hold_go = 1'b1;
        fill_box();
        n = $urandom_range(20, 40);
        repeat (n) begin
            if ($urandom_range(9) == 0)
                send(FUNC_LOAD, 5'($urandom), 5'($urandom), $urandom);
            else
                send(FUNC_SEARCH, 5'($urandom), 5'($urandom), pick_key());
        end
    endtask

    initial begin
        logic [5:0] rows;
        logic [5:0] cols;
        send_idle_pct = 37;
        recv_idle_pct = 48;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // empty matrix straight after reset
        send(FUNC_SEARCH, 5'd31, 5'd31, 32'd0);

        set_shape(6'd1, 6'd4);
        send(FUNC_LOAD, 5'd0, 5'd0, 32'h8000_0000);
        send(FUNC_LOAD, 5'd0, 5'd1, 32'hffff_ffff);
        send(FUNC_LOAD, 5'd0, 5'd2, 32'h0000_0000);
        send(FUNC_LOAD, 5'd0, 5'd3, 32'h7fff_ffff);
        send(FUNC_SEARCH, 5'd0, 5'd0, 32'h8000_0000);
        send(FUNC_SEARCH, 5'd31, 5'd0, 32'h7fff_ffff);
        send(FUNC_SEARCH, 5'd0, 5'd31, 32'hffff_ffff);
        send(FUNC_SEARCH, 5'd17, 5'd10, 32'h0000_0000);
        send(FUNC_SEARCH, 5'd10, 5'd17, 32'h0000_0001);
        send(FUNC_SEARCH, 5'd31, 5'd31, 32'h8000_0001);
        send(FUNC_LOAD, 5'd31, 5'd31, 32'h5555_aaaa);
        send(FUNC_LOAD, 5'd17, 5'd10, 32'haaaa_5555);

        // zero column count
        set_shape(6'd5, 6'd0);
        send(FUNC_SEARCH, 5'd0, 5'd0, 32'h0000_0000);

        // unsorted contents
        set_shape(6'd1, 6'd4);
        send(FUNC_LOAD, 5'd0, 5'd1, 32'd100);
        send(FUNC_SEARCH, 5'd0, 5'd0, 32'd100);
        send(FUNC_SEARCH, 5'd0, 5'd0, 32'd0);

        // saturated counts, long hold-off on replies, empty shapes
        run_phase(6'd63, 6'd1, 1'b0);
        run_phase(6'd1, 6'd63, 1'b0);
        run_phase(6'd32, 6'd2, 1'b1);
        run_phase(6'd0, 6'd63, 1'b0);
        run_phase(6'd63, 6'd0, 1'b0);

        while (n_loads + n_searches < ITEM_TARGET) begin
            case ($urandom_range(9))
                0: begin
                    rows = 6'd0;
                    cols = 6'($urandom);
                end
                1: begin
                    rows = 6'($urandom);
                    cols = 6'd0;
                end
                2: begin
                    rows = 6'($urandom_range(32, 63));
                    cols = 6'($urandom_range(1, 2));
                end
                3: begin
                    rows = 6'($urandom_range(1, 2));
                    cols = 6'($urandom_range(32, 63));
                end
                default: begin
                    rows = 6'($urandom_range(1, 4));
                    cols = 6'($urandom_range(1, 8));
                end
            endcase
            run_phase(rows, cols, 1'b0);
        end

        drain();
        repeat (20) @(posedge aclk);
        $display("tb: %0d loads, %0d searches (%0d found) over %0d matrix shapes",
                 n_loads, n_searches, hits, n_shapes);
        $display("tb: shapes took in empty, zero-column and saturated counts under random stalls");
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
